// ===== design/psu_pkg.sv =====
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
// Used by png_scanline_unfilter; depends on nothing else.
package psu_pkg;

	localparam int MAX_LINE_BYTES  = 8192;
	localparam int MAX_PIXEL_BYTES = 8;

	localparam int LB_W      = 14;                        // line_bytes register width
	localparam int PB_W      = 4;                         // pixel_bytes register width
	localparam int COL_W     = $clog2(MAX_LINE_BYTES);    // column inside a row
	localparam int FILL_W    = $clog2(MAX_LINE_BYTES + 1);
	localparam int WIN_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	typedef enum logic [0:0] {
		CFG_LINE_BYTES  = 1'b0,
		CFG_PIXEL_BYTES = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_code_t;

	typedef enum logic [1:0] {
		KIND_FILTER,
		KIND_DATA,
		KIND_BAD
	} item_kind_t;

	// Paeth predictor: pick the neighbor closest to a + b - c, ties go a, then b.
	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
		pa = da[9] ? 10'(-da) : 10'(da);
		pb = db[9] ? 10'(-db) : 10'(db);
		pc = dc[9] ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

endpackage

// ===== design/png_scanline_unfilter.sv =====
// PNG scanline reconstruction (filter types None, Sub, Up, Average, Paeth).
// Top level; depends on psu_pkg for types, sizes and the Paeth predictor.
//
// channel  dir  handshake         payload
// s_*      in   tvalid / tready   tdata = stream_byte, tuser = image_start
// m_*      out  tvalid / tready   tdata = pixel_byte, tlast = row_end, tuser = bad_filter
// cfg_*    in   cfg_we            cfg_idx selects line_bytes or pixel_bytes
//
// One beat per cycle sustained while the output is not stalled. A beat is decoded and its
// column issued to the line store on acceptance; the work stage then forms the predictor
// and loads the output register. The line store is a single memory with one read and one
// write port; a fill count stands in for clearing it, so there is no clearing pass after
// reset. A stalled output holds the work stage, and the input then waits; filter type
// beats in the work stage never wait on the output.
module png_scanline_unfilter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] stream_byte
	input  logic       s_tuser,   // [0] image_start
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] pixel_byte
	output logic       m_tlast,
	output logic       m_tuser,   // [0] bad_filter
	input  logic                    cfg_we,
	input  logic                    cfg_idx,
	input  logic [psu_pkg::LB_W-1:0] cfg_wdata
);

	localparam int LB_W  = psu_pkg::LB_W;
	localparam int PB_W  = psu_pkg::PB_W;
	localparam int COL_W = psu_pkg::COL_W;
	localparam int FL_W  = psu_pkg::FILL_W;
	localparam int WI_W  = psu_pkg::WIN_IDX_W;
	localparam int NWIN  = psu_pkg::MAX_PIXEL_BYTES;

	// configuration
	logic [LB_W-1:0] line_bytes_q;
	logic [PB_W-1:0] pixel_bytes_q;
	logic [LB_W-1:0] lb_eff;
	logic [PB_W-1:0] pb_eff;
	logic [WI_W-1:0] win_idx;

	// row control, updated on acceptance unless the beat is dropped
	logic [COL_W-1:0] col_q;
	logic [FL_W-1:0]  fill_q;
	logic             expect_q;
	logic             error_q;
	psu_pkg::filter_code_t row_filter_q;

	// work stage
	logic             s1_valid;
	psu_pkg::item_kind_t s1_kind;
	logic [7:0]       s1_byte;
	psu_pkg::filter_code_t s1_filter;
	logic [COL_W-1:0] s1_col;
	logic             s1_last;
	logic             s1_b_ok;
	logic             s1_a_ok;
	logic [7:0]       above_rd_q;

	logic [7:0] left_q   [NWIN];
	logic [7:0] upleft_q [NWIN];
	logic [7:0] above_mem [psu_pkg::MAX_LINE_BYTES];

	logic             accept;
	logic             s1_adv;
	logic             start;
	logic             eff_error;
	logic             eff_expect;
	logic [FL_W-1:0]  eff_fill;
	logic             is_bad;
	logic             data_beat;
	logic [LB_W-1:0]  col_next;
	logic             last_beat;
	logic [FL_W-1:0]  fill_next;

	logic [7:0] nb_a;
	logic [7:0] nb_b;
	logic [7:0] nb_c;
	logic [7:0] pred;
	logic [8:0] avg_sum;
	logic [7:0] val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q  <= LB_W'(1);
			pixel_bytes_q <= PB_W'(1);
		end else if (cfg_we) begin
			case (psu_pkg::cfg_index_t'(cfg_idx))
				psu_pkg::CFG_LINE_BYTES:  line_bytes_q  <= cfg_wdata;
				psu_pkg::CFG_PIXEL_BYTES: pixel_bytes_q <= cfg_wdata[PB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (line_bytes_q == '0) begin
			lb_eff = LB_W'(1);
		end else if (line_bytes_q > LB_W'(psu_pkg::MAX_LINE_BYTES)) begin
			lb_eff = LB_W'(psu_pkg::MAX_LINE_BYTES);
		end else begin
			lb_eff = line_bytes_q;
		end
		if (pixel_bytes_q == '0) begin
			pb_eff = PB_W'(1);
		end else if (pixel_bytes_q > PB_W'(NWIN)) begin
			pb_eff = PB_W'(NWIN);
		end else begin
			pb_eff = pixel_bytes_q;
		end
		win_idx = WI_W'(pb_eff - PB_W'(1));
	end

	// Filter type beats carry no result, so they leave the work stage regardless of m_tready.
	assign s1_adv   = s1_valid && (s1_kind == psu_pkg::KIND_FILTER || !m_tvalid || m_tready);
	assign s_tready = !s1_valid || s1_adv;
	assign accept   = s_tvalid && s_tready;

	// Decode of the incoming beat against the row state, with start of image applied first.
	always_comb begin
		start      = s_tuser;
		eff_error  = start ? 1'b0 : error_q;
		eff_expect = start ? 1'b1 : expect_q;
		eff_fill   = start ? '0 : fill_q;
		is_bad     = s_tdata > {5'd0, psu_pkg::FILT_PAETH};
		data_beat  = !eff_error && !eff_expect;
		col_next   = LB_W'(col_q) + LB_W'(1);
		last_beat  = col_next >= lb_eff;
		fill_next  = (FL_W'(col_next) > fill_q) ? FL_W'(col_next) : fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			fill_q       <= '0;
			expect_q     <= 1'b1;
			error_q      <= 1'b0;
			row_filter_q <= psu_pkg::FILT_NONE;
		end else if (accept && !eff_error) begin
			if (eff_expect) begin
				fill_q   <= eff_fill;
				col_q    <= '0;
				if (is_bad) begin
					error_q  <= 1'b1;
					expect_q <= 1'b1;
				end else begin
					error_q      <= 1'b0;
					expect_q     <= 1'b0;
					row_filter_q <= psu_pkg::filter_code_t'(s_tdata[2:0]);
				end
			end else begin
				fill_q   <= fill_next;
				col_q    <= last_beat ? '0 : col_next[COL_W-1:0];
				expect_q <= last_beat;
			end
		end
	end

	// Dropped beats (sticky error) never enter the work stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= accept && !eff_error;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_byte   <= s_tdata;
			s1_filter <= row_filter_q;
			s1_col    <= col_q;
			s1_last   <= last_beat;
			s1_b_ok   <= FL_W'(col_q) < fill_q;
			s1_a_ok   <= col_q >= COL_W'(pb_eff);
			if (data_beat) begin
				s1_kind <= psu_pkg::KIND_DATA;
			end else if (is_bad) begin
				s1_kind <= psu_pkg::KIND_BAD;
			end else begin
				s1_kind <= psu_pkg::KIND_FILTER;
			end
		end
	end

	// Line store: read ahead on acceptance, written back when the byte leaves the work stage.
	always_ff @(posedge clk) begin
		if (accept && data_beat) begin
			above_rd_q <= above_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_kind == psu_pkg::KIND_DATA) begin
			above_mem[s1_col] <= val;
		end
	end

	always_comb begin
		nb_b    = s1_b_ok ? above_rd_q : 8'd0;
		nb_a    = s1_a_ok ? left_q[win_idx] : 8'd0;
		nb_c    = s1_a_ok ? upleft_q[win_idx] : 8'd0;
		avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
		case (s1_filter)
			psu_pkg::FILT_NONE:  pred = 8'd0;
			psu_pkg::FILT_SUB:   pred = nb_a;
			psu_pkg::FILT_UP:    pred = nb_b;
			psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
			psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pick(nb_a, nb_b, nb_c);
			default:             pred = 8'd0;
		endcase
		val = s1_byte + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NWIN; k++) begin
				left_q[k]   <= 8'd0;
				upleft_q[k] <= 8'd0;
			end
		end else if (s1_adv) begin
			if (s1_kind == psu_pkg::KIND_DATA) begin
				left_q[0]   <= val;
				upleft_q[0] <= nb_b;
				for (int k = 1; k < NWIN; k++) begin
					left_q[k]   <= left_q[k-1];
					upleft_q[k] <= upleft_q[k-1];
				end
			end else if (s1_kind == psu_pkg::KIND_FILTER) begin
				for (int k = 0; k < NWIN; k++) begin
					left_q[k]   <= 8'd0;
					upleft_q[k] <= 8'd0;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_adv && s1_kind != psu_pkg::KIND_FILTER) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_kind != psu_pkg::KIND_FILTER) begin
			if (s1_kind == psu_pkg::KIND_BAD) begin
				m_tdata <= 8'd0;
				m_tlast <= 1'b0;
				m_tuser <= 1'b1;
			end else begin
				m_tdata <= val;
				m_tlast <= s1_last;
				m_tuser <= 1'b0;
			end
		end
	end

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'd0 && !m_tlast)
		else $error("bad filter beat with nonzero payload");

	a_drop_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept && error_q && !s_tuser |=> $stable(col_q) && $stable(fill_q) && error_q)
		else $error("dropped beat changed row state");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FL_W'(psu_pkg::MAX_LINE_BYTES))
		else $error("line store fill count out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_adv |=> s1_valid && $stable(s1_byte) && $stable(s1_col))
		else $error("work stage lost a stalled beat");

endmodule

// ===== bench/png_scanline_unfilter_test.sv =====
// Self-checking testbench for png_scanline_unfilter: PNG row reconstruction checked beat by beat
// against an in-bench prediction of all five filter types, bad codes and image restarts.
// Depends on psu_pkg and png_scanline_unfilter only.
module png_scanline_unfilter_test;
	import psu_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HOLD    = 400;
	localparam int N_PHASES     = 10;
	localparam int PHASE_BEATS  = 180;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} stream_beat_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       row_end;
		logic       bad;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic cfg_idx = CFG_LINE_BYTES;
	logic [LB_W-1:0] cfg_wdata = '0;

	png_scanline_unfilter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the block's state
	logic [7:0]      prev_row [0:MAX_LINE_BYTES-1];
	logic [7:0]      left_win [0:MAX_PIXEL_BYTES-1];
	logic [7:0]      upleft_win [0:MAX_PIXEL_BYTES-1];
	int              row_col;
	logic            awaiting_filter;
	filter_code_t    row_filter;
	logic            on_first_row;
	logic            stuck_bad;
	logic [LB_W-1:0] line_bytes_reg;
	logic [PB_W-1:0] pixel_bytes_reg;

	stream_beat_t  beat_q[$];
	pixel_result_t expected_pixels[$];
	stream_beat_t  next_beat;

	int beats_queued = 0;
	int beats_in = 0;
	int images_in = 0;
	int pixels_out = 0;
	int rows_out = 0;
	int bad_codes_out = 0;
	int fail_count = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;

	function automatic int clamp_reg(int v, int hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [7:0] closest_neighbor(logic [7:0] a, logic [7:0] b,
		logic [7:0] c);
		int est;
		int da;
		int db;
		int dc;
		est = int'(a) + int'(b) - int'(c);
		da = est - int'(a);
		db = est - int'(b);
		dc = est - int'(c);
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) begin
			return a;
		end
		return (db <= dc) ? b : c;
	endfunction

	task automatic restart_image();
		for (int k = 0; k < MAX_LINE_BYTES; k++) prev_row[k] = 8'd0;
		for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
			left_win[k] = 8'd0;
			upleft_win[k] = 8'd0;
		end
		row_col = 0;
		awaiting_filter = 1'b1;
		row_filter = FILT_NONE;
		on_first_row = 1'b1;
		stuck_bad = 1'b0;
	endtask

	// Works out what one accepted stream beat produces and queues it.
	task automatic unfilter_beat(input logic [7:0] x, input logic start);
		int lb;
		int pb;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] pred;
		logic [8:0] sum;
		pixel_result_t r;
		lb = clamp_reg(int'(line_bytes_reg), MAX_LINE_BYTES);
		pb = clamp_reg(int'(pixel_bytes_reg), MAX_PIXEL_BYTES);
		a = 8'd0;
		b = 8'd0;
		c = 8'd0;
		if (start) begin
			restart_image();
			images_in++;
		end
		if (stuck_bad) begin
			return;
		end
		if (awaiting_filter) begin
			if (x > 8'(FILT_PAETH)) begin
				stuck_bad = 1'b1;
				r.pixel = 8'd0;
				r.row_end = 1'b0;
				r.bad = 1'b1;
				expected_pixels.push_back(r);
				return;
			end
			row_filter = filter_code_t'(x[2:0]);
			awaiting_filter = 1'b0;
			row_col = 0;
			for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
				left_win[k] = 8'd0;
				upleft_win[k] = 8'd0;
			end
			return;
		end
		if (!on_first_row) b = prev_row[row_col];
		if (row_col >= pb) begin
			a = left_win[pb-1];
			c = upleft_win[pb-1];
		end
		case (row_filter)
			FILT_SUB: pred = a;
			FILT_UP: pred = b;
			FILT_AVG: begin
				sum = 9'(a) + 9'(b);
				pred = sum[8:1];
			end
			FILT_PAETH: pred = closest_neighbor(a, b, c);
			default: pred = 8'd0;
		endcase
		r.pixel = x + pred;
		r.bad = 1'b0;
		for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
			upleft_win[k] = upleft_win[k-1];
			left_win[k] = left_win[k-1];
		end
		upleft_win[0] = b;
		left_win[0] = r.pixel;
		prev_row[row_col] = r.pixel;
		r.row_end = (row_col + 1 >= lb);
		if (r.row_end) begin
			awaiting_filter = 1'b1;
			on_first_row = 1'b0;
			row_col = 0;
		end else begin
			row_col++;
		end
		expected_pixels.push_back(r);
	endtask

	// Sender: offers queued beats and predicts each one as it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				unfilter_beat(s_tdata, s_tuser);
				beats_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_beat = beat_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_beat.data;
					s_tuser <= next_beat.start;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result beat and decides the next cycle's ready.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("result beat with nothing expected: pixel_byte %0d row_end %0d bad_filter %0d",
						m_tdata, m_tlast, m_tuser);
					fail_count++;
				end else begin
					pixel_result_t want;
					want = expected_pixels.pop_front();
					if (m_tdata !== want.pixel) begin
						$error("pixel_byte: expected %0d, got %0d", want.pixel, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.row_end) begin
						$error("row_end: expected %0d, got %0d", want.row_end, m_tlast);
						fail_count++;
					end
					if (m_tuser !== want.bad) begin
						$error("bad_filter: expected %0d, got %0d", want.bad, m_tuser);
						fail_count++;
					end
				end
				pixels_out++;
				if (m_tlast === 1'b1) rows_out++;
				if (m_tuser === 1'b1) bad_codes_out++;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles,
				expected_pixels.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_beat(input logic [7:0] data, input logic start);
		stream_beat_t bt;
		bt.data = data;
		bt.start = start;
		beat_q.push_back(bt);
		beats_queued++;
	endtask

	function automatic logic [7:0] random_data();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5) return 8'd0;
		if (roll < 10) return 8'd255;
		return 8'($urandom_range(255));
	endfunction

	task automatic push_row(input logic [7:0] filt, input logic start, input int n);
		push_beat(filt, start);
		for (int k = 0; k < n; k++) push_beat(random_data(), 1'b0);
	endtask

	// Waits until every queued beat is taken and every result has come back.
	task automatic drain();
		while (beats_in != beats_queued) @(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [LB_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		if (idx == CFG_LINE_BYTES) begin
			line_bytes_reg = value;
		end else begin
			pixel_bytes_reg = value[PB_W-1:0];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed images with random content; some rows are cut short, some filter
	// codes are bad and followed by bytes that get dropped, and a few starts land mid-image.
	task automatic random_images(input int target, input bit continue_first);
		int made;
		int rows;
		int n;
		int lb;
		logic [7:0] filt;
		logic start;
		bit first;
		made = 0;
		first = 1'b1;
		lb = clamp_reg(int'(line_bytes_reg), MAX_LINE_BYTES);
		while (made < target) begin
			rows = $urandom_range(1, 4);
			for (int r = 0; r < rows; r++) begin
				start = (r == 0) && !(first && continue_first);
				if ($urandom_range(99) < 8) begin
					filt = 8'($urandom_range(5, 255));
				end else begin
					filt = 8'($urandom_range(0, 4));
				end
				n = lb;
				if ($urandom_range(99) < 5) n = $urandom_range(0, lb - 1);
				if (filt > 8'(FILT_PAETH)) n = $urandom_range(0, 3);
				push_row(filt, start, n);
				made = made + 1 + ((filt > 8'(FILT_PAETH)) ? 0 : n);
				if (filt > 8'(FILT_PAETH) || n < lb) break;
				if ($urandom_range(99) < 3) begin
					push_beat(8'($urandom_range(255)), 1'b1);
					made++;
				end
			end
			first = 1'b0;
		end
	endtask

	initial begin
		int lb_set [N_PHASES];
		int pb_set [N_PHASES];
		lb_set = '{0, 5, 16383, 1, 12, 7, 8, 24, 2, 9};
		pb_set = '{0, 3, 15, 8, 4, 7, 8, 6, 2, 1};
		line_bytes_reg = 1;
		pixel_bytes_reg = 1;
		restart_image();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: one row per filter type with byte extremes, then bad codes and restarts.
		write_reg(CFG_LINE_BYTES, LB_W'(3));
		write_reg(CFG_PIXEL_BYTES, LB_W'(1));
		push_beat(8'(FILT_NONE), 1'b1);
		push_beat(8'd0, 1'b0);
		push_beat(8'd255, 1'b0);
		push_beat(8'd128, 1'b0);
		push_beat(8'(FILT_SUB), 1'b0);
		push_beat(8'd255, 1'b0);
		push_beat(8'd1, 1'b0);
		push_beat(8'd255, 1'b0);
		push_beat(8'(FILT_UP), 1'b0);
		push_beat(8'd200, 1'b0);
		push_beat(8'd100, 1'b0);
		push_beat(8'd0, 1'b0);
		push_beat(8'(FILT_AVG), 1'b0);
		push_beat(8'd255, 1'b0);
		push_beat(8'd255, 1'b0);
		push_beat(8'd255, 1'b0);
		push_beat(8'(FILT_PAETH), 1'b0);
		push_beat(8'd17, 1'b0);
		push_beat(8'd0, 1'b0);
		push_beat(8'd255, 1'b0);
		push_beat(8'd5, 1'b0);
		push_beat(8'd9, 1'b0);
		push_beat(8'd255, 1'b1);
		push_row(8'(FILT_PAETH), 1'b1, 3);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 53;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 53;
				end
				default: begin
					send_idle_pct = 6;
					recv_stall_pct = 6;
				end
			endcase
			write_reg(CFG_LINE_BYTES, LB_W'(lb_set[p]));
			write_reg(CFG_PIXEL_BYTES, LB_W'(pb_set[p]));
			// The output side freezes while the input keeps offering beats.
			if (p % 4 == 0) hold_requests++;
			if (clamp_reg(int'(line_bytes_reg), MAX_LINE_BYTES) == MAX_LINE_BYTES) begin
				// The saturated row width keeps this row open; a later filter byte is
				// taken as data, and a restart cuts the row short.
				push_row(8'(FILT_PAETH), 1'b1, 60);
				push_row(8'(FILT_AVG), 1'b0, 20);
				push_row(8'(FILT_SUB), 1'b1, 20);
			end else begin
				random_images(PHASE_BEATS, p % 3 == 1);
			end
			drain();
		end

		$display("Accepted %0d stream beats over %0d images; checked %0d result beats.",
			beats_in, images_in, pixels_out);
		$display("Rows completed: %0d, bad filter codes reported: %0d, long output holds: %0d.",
			rows_out, bad_codes_out, holds_served);
		if (fail_count == 0 && expected_pixels.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/psu_pkg.sv
design/png_scanline_unfilter.sv
bench/png_scanline_unfilter_test.sv
